/* sv/irls_pkg.sv */
// shared constants, types and sigmoid table builder for the irls weight update unit
package irls_pkg;

	// field widths
	localparam int ETA_W   = 32;
	localparam int Y_W     = 17;
	localparam int FLOOR_W = 15;
	localparam int WT_W    = 15;
	localparam int P_W     = 17;
	localparam int PC_W    = 16;
	localparam int MAG_W   = 17;
	localparam int W32_W   = 31;

	// sigmoid table geometry
	localparam int SIGMOID_ENTRIES = 1024;
	localparam int IDX_W           = $clog2(SIGMOID_ENTRIES);
	localparam int SPAN_SHIFT      = 21;
	localparam int PROD_W          = SPAN_SHIFT + IDX_W;
	localparam int HALF_SPAN       = 1 << (SPAN_SHIFT - 1);

	// divider geometry: quotient below 2^34, dividend below 2^49, remainder below 2^31
	localparam int QUO_W = 34;
	localparam int DVD_W = MAG_W + 32;
	localparam int REM_W = W32_W;

	localparam logic [63:0] ONE_Q16      = 64'd65536;
	localparam logic [63:0] ONE_Q32      = 64'h1_0000_0000;
	localparam logic [63:0] LN2_Q32      = 64'd2977044472;
	localparam int          SERIES_TERMS = 12;

	typedef logic [P_W-1:0] sig_table_t [SIGMOID_ENTRIES];

	// shift-subtract unsigned divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-r) in Q32 for 0 <= r < ln2, truncated series
	function automatic logic [63:0] exp_neg_small(input logic [63:0] r);
		logic [63:0]        rr;
		logic [63:0]        term;
		logic signed [63:0] sum;
		rr   = {48'd0, r[31:16]};
		term = ONE_Q32;
		sum  = signed'(ONE_Q32);
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = udiv64((term * rr) >> 16, 64'(k));
			if ((k % 2) == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > signed'(ONE_Q32)) begin
			sum = signed'(ONE_Q32);
		end
		return unsigned'(sum);
	endfunction

	// sigmoid at the center of bin k, Q0.16
	function automatic logic [P_W-1:0] sigmoid_entry(input int k);
		logic [63:0]        num;
		logic signed [63:0] s;
		logic [63:0]        a;
		logic [63:0]        n;
		logic [63:0]        r;
		logic [63:0]        e;
		logic [63:0]        d;
		logic [63:0]        q;
		num = ((64'(2 * k) + 64'd1) << 36) / SIGMOID_ENTRIES;
		s   = signed'(num) - signed'(64'd1 << 36);
		a   = (s < 0) ? unsigned'(-s) : unsigned'(s);
		n   = a / LN2_Q32;
		r   = a - n * LN2_Q32;
		e   = (n >= 64'd40) ? 64'd0 : (exp_neg_small(r) >> n);
		d   = ONE_Q32 + e;
		q   = udiv64((e << 16) + (d >> 1), d);
		return (s < 0) ? P_W'(q) : P_W'(ONE_Q16 - q);
	endfunction

	function automatic sig_table_t build_sig_table();
		sig_table_t t;
		for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
			t[k] = sigmoid_entry(k);
		end
		return t;
	endfunction

	localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

/* sv/irls_logistic_weight_update_top.sv */
// irls logistic weight update: sigmoid lookup, clamp, weight and working response
// pipeline: five front stages, then a 34-stage pipelined restoring divider
//   and an output register
// throughput: one request per cycle; a stalled output freezes the whole pipeline
// reset: arst_n clears all valid bits and sets the floor register to 1
module irls_logistic_weight_update_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [irls_pkg::FLOOR_W-1:0]        prob_floor,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [irls_pkg::ETA_W-1:0]   linear_predictor,
	input  logic [irls_pkg::Y_W-1:0]            response,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [irls_pkg::WT_W-1:0]           weight,
	output logic signed [irls_pkg::ETA_W-1:0]   working_response,
	output logic                                saturated
);
	import irls_pkg::*;

	logic adv;

	// config register
	logic [FLOOR_W-1:0] floor_q;

	// stage 1: table index
	logic                     vld_s1;
	logic signed [ETA_W-1:0]  eta_s1;
	logic [Y_W-1:0]           y_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [ETA_W:0]    v_c;
	logic [PROD_W-1:0]        prod_c;
	logic [IDX_W-1:0]         idx_c;

	// stage 2: table read
	logic                     vld_s2;
	logic signed [ETA_W-1:0]  eta_s2;
	logic [Y_W-1:0]           y_s2;
	logic [P_W-1:0]           praw_s2;

	// stage 3: clamp and numerator
	logic                     vld_s3;
	logic signed [ETA_W-1:0]  eta_s3;
	logic [PC_W-1:0]          p_s3;
	logic [MAG_W-1:0]         mag_s3;
	logic                     neg_s3;
	logic [FLOOR_W-1:0]       lo_c;
	logic [P_W-1:0]           hi_c;
	logic [P_W-1:0]           pc_c;
	logic signed [Y_W:0]      num_c;

	// stage 4: weight product
	logic                     vld_s4;
	logic signed [ETA_W-1:0]  eta_s4;
	logic [MAG_W-1:0]         mag_s4;
	logic                     neg_s4;
	logic [W32_W-1:0]         w32_s4;
	logic [PC_W+P_W-1:0]      wprod_c;

	// stage 5: dividend and rounded weight
	logic                     vld_s5;
	logic signed [ETA_W-1:0]  eta_s5;
	logic                     neg_s5;
	logic [W32_W-1:0]         w32_s5;
	logic [DVD_W-1:0]         dvd_s5;
	logic [WT_W-1:0]          wt_s5;
	logic [W32_W-1:0]         wround_c;

	// divider stages, index 0 fed from stage 5
	logic                     dv_vld_s [QUO_W+1];
	logic signed [ETA_W-1:0]  dv_eta_s [QUO_W+1];
	logic                     dv_neg_s [QUO_W+1];
	logic [W32_W-1:0]         dv_w_s   [QUO_W+1];
	logic [WT_W-1:0]          dv_wt_s  [QUO_W+1];
	logic [REM_W-1:0]         dv_rem_s [QUO_W+1];
	logic [QUO_W-1:0]         dv_sh_s  [QUO_W+1];

	// output stage
	logic                     vld_out_q;
	logic [WT_W-1:0]          wt_q;
	logic signed [ETA_W-1:0]  z_q;
	logic                     sat_q;
	logic [QUO_W-1:0]         quot_c;
	logic signed [QUO_W+1:0]  q_c;
	logic signed [QUO_W+1:0]  z_c;
	logic                     sat_c;
	logic signed [ETA_W-1:0]  zsat_c;

	// global advance: everything moves unless a finished result is held
	assign adv       = !vld_out_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_W'(1);
		end else if (cfg_valid) begin
			floor_q <= prob_floor;
		end
	end

	// index: clamp below, clamp above, else scale bin offset
	always_comb begin
		v_c    = {linear_predictor[ETA_W-1], linear_predictor} + (ETA_W+1)'(HALF_SPAN);
		prod_c = PROD_W'(v_c[SPAN_SHIFT-1:0]) * PROD_W'(SIGMOID_ENTRIES);
		if (v_c < 0) begin
			idx_c = '0;
		end else if (v_c >= (ETA_W+1)'(1 << SPAN_SHIFT)) begin
			idx_c = IDX_W'(SIGMOID_ENTRIES - 1);
		end else begin
			idx_c = prod_c[PROD_W-1:SPAN_SHIFT];
		end
	end

	// front stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1 and 2 payload, table read registered
	always_ff @(posedge clk) begin
		if (adv) begin
			eta_s1  <= linear_predictor;
			y_s1    <= response;
			idx_s1  <= idx_c;
			eta_s2  <= eta_s1;
			y_s2    <= y_s1;
			praw_s2 <= SIG_TABLE[idx_s1];
		end
	end

	// clamp p and form y - p
	always_comb begin
		lo_c  = (floor_q == '0) ? FLOOR_W'(1) : floor_q;
		hi_c  = P_W'(ONE_Q16) - P_W'(lo_c);
		if (praw_s2 < P_W'(lo_c)) begin
			pc_c = P_W'(lo_c);
		end else if (praw_s2 > hi_c) begin
			pc_c = hi_c;
		end else begin
			pc_c = praw_s2;
		end
		num_c = signed'({1'b0, y_s2}) - signed'({1'b0, pc_c});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eta_s3 <= eta_s2;
			p_s3   <= pc_c[PC_W-1:0];
			neg_s3 <= num_c[Y_W];
			mag_s3 <= num_c[Y_W] ? MAG_W'(-num_c) : MAG_W'(num_c);
		end
	end

	// weight product p * (1 - p), exact Q0.32
	assign wprod_c = (PC_W+P_W)'(p_s3) * (PC_W+P_W)'(P_W'(ONE_Q16) - P_W'(p_s3));

	always_ff @(posedge clk) begin
		if (adv) begin
			eta_s4 <= eta_s3;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			w32_s4 <= W32_W'(wprod_c);
		end
	end

	// dividend with half divisor for rounding, rounded Q0.16 weight
	assign wround_c = w32_s4 + W32_W'(32768);

	always_ff @(posedge clk) begin
		if (adv) begin
			eta_s5 <= eta_s4;
			neg_s5 <= neg_s4;
			w32_s5 <= w32_s4;
			dvd_s5 <= {mag_s4, 32'd0} + DVD_W'(w32_s4 >> 1);
			wt_s5  <= wround_c[WT_W+15:16];
		end
	end

	// divider entry
	assign dv_vld_s[0] = vld_s5;
	assign dv_eta_s[0] = eta_s5;
	assign dv_neg_s[0] = neg_s5;
	assign dv_w_s[0]   = w32_s5;
	assign dv_wt_s[0]  = wt_s5;
	assign dv_rem_s[0] = REM_W'(dvd_s5[DVD_W-1:QUO_W]);
	assign dv_sh_s[0]  = dvd_s5[QUO_W-1:0];

	// one quotient bit per stage, dividend bits shift out as quotient bits shift in
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		logic [REM_W:0] trial;
		logic           ge;

		always_comb begin
			trial = {dv_rem_s[i], dv_sh_s[i][QUO_W-1]};
			ge    = trial >= {1'b0, dv_w_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[i+1] <= dv_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_eta_s[i+1] <= dv_eta_s[i];
				dv_neg_s[i+1] <= dv_neg_s[i];
				dv_w_s[i+1]   <= dv_w_s[i];
				dv_wt_s[i+1]  <= dv_wt_s[i];
				dv_rem_s[i+1] <= ge ? REM_W'(trial - {1'b0, dv_w_s[i]}) : trial[REM_W-1:0];
				dv_sh_s[i+1]  <= {dv_sh_s[i][QUO_W-2:0], ge};
			end
		end
	end

	// apply sign, add eta, saturate to 32 bits
	always_comb begin
		quot_c = dv_sh_s[QUO_W];
		q_c    = dv_neg_s[QUO_W] ? -signed'({2'b00, quot_c}) : signed'({2'b00, quot_c});
		z_c    = (QUO_W+2)'(dv_eta_s[QUO_W]) + q_c;
		sat_c  = (z_c[QUO_W+1:ETA_W-1] != '0) && (z_c[QUO_W+1:ETA_W-1] != '1);
		if (!sat_c) begin
			zsat_c = z_c[ETA_W-1:0];
		end else if (z_c[QUO_W+1]) begin
			zsat_c = {1'b1, {(ETA_W-1){1'b0}}};
		end else begin
			zsat_c = {1'b0, {(ETA_W-1){1'b1}}};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= dv_vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wt_q  <= dv_wt_s[QUO_W];
			z_q   <= zsat_c;
			sat_q <= sat_c;
		end
	end

	assign out_valid        = vld_out_q;
	assign weight           = wt_q;
	assign working_response = z_q;
	assign saturated        = sat_q;

endmodule

/* dv/irls_weight_checker.sv */
`timescale 1ns / 1ps
// checker that predicts and compares the weight, working response and clip flag of each sample
module irls_weight_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [irls_pkg::FLOOR_W-1:0]      prob_floor,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [irls_pkg::ETA_W-1:0] linear_predictor,
	input  logic [irls_pkg::Y_W-1:0]          response,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [irls_pkg::WT_W-1:0]         weight,
	input  logic signed [irls_pkg::ETA_W-1:0] working_response,
	input  logic                              saturated,
	output int                                mismatches,
	output int                                in_flight
);

	localparam int              LUT_SIZE = irls_pkg::SIGMOID_ENTRIES;
	localparam longint unsigned Q32_ONE  = 64'h1_0000_0000;
	localparam longint unsigned LN2_Q32  = 64'd2977044472;
	localparam longint          Q16_ONE  = 64'sd65536;
	localparam longint          Z_MAX    = 64'sh7FFF_FFFF;
	localparam longint          Z_MIN    = -64'sh8000_0000;

	typedef struct {
		logic [irls_pkg::WT_W-1:0]         weight;
		logic signed [irls_pkg::ETA_W-1:0] z;
		logic                              sat;
	} irls_update_t;

	logic [16:0]                  sigmoid_lut [LUT_SIZE];
	logic [irls_pkg::FLOOR_W-1:0] floor_copy;
	irls_update_t                 pending_updates [$];
	int                           fails;

	// exp(-r) in Q32 for 0 <= r < ln2, twelve series terms on a 16-bit r
	function automatic longint unsigned exp_minus_q32(input longint unsigned r);
		longint unsigned rr;
		longint unsigned term;
		longint          acc;
		rr   = (r >> 16) & 64'hFFFF;
		term = Q32_ONE;
		acc  = longint'(Q32_ONE);
		for (int k = 1; k <= 12; k++) begin
			term = ((term * rr) >> 16) / 64'(k);
			if ((k % 2) == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(Q32_ONE)) begin
			acc = longint'(Q32_ONE);
		end
		return longint'(acc);
	endfunction

	// sigmoid at the center of bin k, Q0.16, rounded to nearest
	function automatic logic [16:0] sigmoid_at_bin(input int k);
		longint unsigned num;
		longint unsigned a;
		longint unsigned n;
		longint unsigned r;
		longint unsigned e;
		longint unsigned d;
		longint unsigned q;
		longint          s;
		num = (64'(2 * k + 1) << 36) / LUT_SIZE;
		s   = longint'(num) - (64'sd1 << 36);
		a   = (s < 0) ? -s : s;
		n   = a / LN2_Q32;
		r   = a - n * LN2_Q32;
		e   = (n >= 40) ? 64'd0 : (exp_minus_q32(r) >> n);
		d   = Q32_ONE + e;
		q   = ((e << 16) + d / 2) / d;
		return (s < 0) ? 17'(q) : 17'(64'd65536 - q);
	endfunction

	// weight, working response and clip flag for one sample
	function automatic irls_update_t compute_update(input logic signed [31:0] eta_in,
			input logic [16:0] y_in, input logic [14:0] floor_in);
		longint          eta;
		longint          y;
		longint          v;
		longint          p;
		longint          lo;
		longint          hi;
		longint          w32;
		longint          diff;
		longint          q;
		longint          z;
		longint          idx;
		longint unsigned mag;
		irls_update_t    res;
		eta = eta_in;
		y   = y_in;
		v   = eta + 64'sd1048576;
		// table index saturates outside [-16, 16)
		if (v < 0) begin
			idx = 0;
		end else begin
			idx = (v * LUT_SIZE) >>> 21;
			if (idx > LUT_SIZE - 1) begin
				idx = LUT_SIZE - 1;
			end
		end
		p = sigmoid_lut[idx];
		// a zero floor acts as one
		lo = (floor_in == 0) ? 64'sd1 : longint'(floor_in);
		hi = Q16_ONE - lo;
		if (p < lo) begin
			p = lo;
		end
		if (p > hi) begin
			p = hi;
		end
		w32  = p * (Q16_ONE - p);
		diff = y - p;
		mag  = (diff < 0) ? -diff : diff;
		mag  = ((mag << 32) + 64'(w32 / 2)) / 64'(w32);
		q    = (diff < 0) ? -longint'(mag) : longint'(mag);
		z    = eta + q;
		res.sat = 1'b0;
		if (z > Z_MAX) begin
			z       = Z_MAX;
			res.sat = 1'b1;
		end else if (z < Z_MIN) begin
			z       = Z_MIN;
			res.sat = 1'b1;
		end
		res.z      = 32'(z);
		res.weight = irls_pkg::WT_W'((w32 + 32768) >>> 16);
		return res;
	endfunction

	// sigmoid table of the checker's own
	initial begin
		for (int k = 0; k < LUT_SIZE; k++) begin
			sigmoid_lut[k] = sigmoid_at_bin(k);
		end
	end

	// watch the config, sample and result channels
	always @(posedge clk or negedge arst_n) begin
		irls_update_t want;
		if (!arst_n) begin
			floor_copy <= 15'd1;
			pending_updates.delete();
			in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				floor_copy <= prob_floor;
			end
			if (in_valid && in_ready) begin
				pending_updates.push_back(compute_update(linear_predictor, response,
					floor_copy));
			end
			if (out_valid && out_ready) begin
				if (pending_updates.size() == 0) begin
					$error("result with no request pending: weight %0d z %0d sat %0d",
						weight, working_response, saturated);
					fails++;
				end else begin
					want = pending_updates.pop_front();
					if (weight !== want.weight) begin
						$error("weight: expected %0d, got %0d", want.weight, weight);
						fails++;
					end
					if (working_response !== want.z) begin
						$error("working_response: expected %0d, got %0d", want.z,
							working_response);
						fails++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0d, got %0d", want.sat, saturated);
						fails++;
					end
				end
			end
			in_flight  <= pending_updates.size();
			mismatches <= fails;
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench top: drives samples and floor writes into the irls unit and gives the verdict
module testbench;

	localparam int N_CORNERS  = 20;
	localparam int PHASE_SIZE = 346;

	// corner samples: range ends, table edges, bin edges, response extremes
	localparam logic signed [31:0] CORNER_ETA [N_CORNERS] = '{
		32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
		32'sd0, 32'sd0, 32'sd0, -32'sd1,
		32'sd1048575, 32'sd1048576, -32'sd1048576, -32'sd1048577,
		-32'sd1048575, 32'sd2047, 32'sd2048, -32'sd2048,
		32'sd655360, -32'sd655360, 32'sh4000_0000, 32'shC000_0000
	};
	localparam logic [16:0] CORNER_Y [N_CORNERS] = '{
		17'd0, 17'd131071, 17'd0, 17'd131071,
		17'd32768, 17'd0, 17'd65536, 17'd65536,
		17'd65536, 17'd0, 17'd65536, 17'd65536,
		17'd0, 17'd0, 17'd131071, 17'd65535,
		17'd0, 17'd65536, 17'd0, 17'd65536
	};

	logic                              clk              = 1'b0;
	logic                              arst_n           = 1'b0;
	logic                              cfg_valid        = 1'b0;
	logic [irls_pkg::FLOOR_W-1:0]      prob_floor       = 15'd1;
	logic                              in_valid         = 1'b0;
	logic signed [irls_pkg::ETA_W-1:0] linear_predictor = '0;
	logic [irls_pkg::Y_W-1:0]          response         = '0;
	logic                              out_ready        = 1'b0;
	logic                              cfg_ready;
	logic                              in_ready;
	logic                              out_valid;
	logic [irls_pkg::WT_W-1:0]         weight;
	logic signed [irls_pkg::ETA_W-1:0] working_response;
	logic                              saturated;
	int                                mismatches;
	int                                in_flight;
	bit                                calm     = 1'b0;
	bit                                hold_req = 1'b0;

	irls_logistic_weight_update_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.prob_floor       (prob_floor),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.linear_predictor (linear_predictor),
		.response         (response),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.weight           (weight),
		.working_response (working_response),
		.saturated        (saturated)
	);

	irls_weight_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.prob_floor       (prob_floor),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.linear_predictor (linear_predictor),
		.response         (response),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.weight           (weight),
		.working_response (working_response),
		.saturated        (saturated),
		.mismatches       (mismatches),
		.in_flight        (in_flight)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		#1_600_000;
		$display("testbench: done, errors");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (250) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 26);
			end
		end
	end

	// offer one sample, with a random gap ahead of it
	task automatic offer_sample(input logic signed [31:0] eta, input logic [16:0] y);
		if (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		linear_predictor <= eta;
		response         <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	// random sample: mostly inside the table span with 0/1 responses
	task automatic offer_random_sample();
		int          pick;
		logic [31:0] eta;
		logic [16:0] y;
		pick = $urandom_range(99);
		if (pick < 55) begin
			eta = int'($urandom_range(0, 2621440)) - 1310720;
		end else if (pick < 72) begin
			eta = int'($urandom_range(0, 131072)) - 65536;
		end else if (pick < 90) begin
			eta = $urandom();
		end else if (pick < 95) begin
			eta = 32'h7FFF_FFFF - $urandom_range(0, 4194304);
		end else begin
			eta = 32'h8000_0000 + $urandom_range(0, 4194304);
		end
		pick = $urandom_range(99);
		if (pick < 35) begin
			y = 17'd0;
		end else if (pick < 70) begin
			y = 17'd65536;
		end else if (pick < 90) begin
			y = $urandom_range(0, 65536);
		end else begin
			y = $urandom_range(0, 131071);
		end
		offer_sample(eta, y);
	endtask

	// stop sending and wait until every result is back and the pipe is empty
	task automatic let_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_floor(input logic [irls_pkg::FLOOR_W-1:0] f);
		cfg_valid  <= 1'b1;
		prob_floor <= f;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		logic [irls_pkg::FLOOR_W-1:0] floors [5];
		floors = '{15'd32767, 15'd0, 15'd1, 15'd300, 15'($urandom_range(1, 32767))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners under the reset floor
		for (int i = 0; i < N_CORNERS; i++) begin
			offer_sample(CORNER_ETA[i], CORNER_Y[i]);
		end
		let_drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_floor(floors[ph]);
			// extreme floors also see every third corner
			if (ph < 2) begin
				for (int i = 0; i < N_CORNERS; i += 3) begin
					offer_sample(CORNER_ETA[i], CORNER_Y[i]);
				end
			end
			calm = (ph == 2);
			for (int i = 0; i < PHASE_SIZE; i++) begin
				if (ph == 1 && i == 170) begin
					let_drain();
				end
				if (ph == 3 && i == 120) begin
					hold_req = 1'b1;
				end
				offer_random_sample();
			end
			calm = 1'b0;
			let_drain();
		end

		if (mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
